/* hw/rtl/dra_pkg.sv */
// Shared types and defaults for the dirty rectangle accumulator.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package dra_pkg;

  localparam int MAX_RECTS_DEF  = 16;
  localparam int COORD_BITS_DEF = 12;
  localparam int FIELD_W        = 12;

  // Request kinds.
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_CONTAINED = 2'd0;
  localparam logic [1:0] ST_MERGED    = 2'd1;
  localparam logic [1:0] ST_APPENDED  = 2'd2;
  localparam logic [1:0] ST_FORCED    = 2'd3;

  typedef struct packed {
    logic               req_type;
    logic [FIELD_W-1:0] rect_left;
    logic [FIELD_W-1:0] rect_top;
    logic [FIELD_W-1:0] rect_right;
    logic [FIELD_W-1:0] rect_bottom;
  } req_t;

  typedef struct packed {
    logic [1:0]         add_status;
    logic [3:0]         entry_index;
    logic [FIELD_W-1:0] out_left;
    logic [FIELD_W-1:0] out_top;
    logic [FIELD_W-1:0] out_right;
    logic [FIELD_W-1:0] out_bottom;
    logic               list_empty;
    logic               last_item;
  } res_t;

  // Controls for one storage cell of the ring.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  // Controls for the rectangle evaluation unit.
  typedef struct packed {
    logic load_new;
    logic eval_en;
  } eval_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/dirty_rect_accumulator_unit.sv */
// Dirty rectangle accumulator top level: ring of rectangle cells, evaluation unit, sequencer.
// Depends on dra_pkg, dra_cell and dra_eval.
//
// Stored rectangles sit in a ring of MAX_RECTS cells that rotates one place per cycle past
// a single evaluation unit, and the ring's rotation sets the timing. An add ends after the
// containment rotation when a stored rectangle contains it. When it merges, it runs a
// containment rotation, then a merge rotation plus a final step for the area pipeline. When
// it is appended or forced into the last entry, it adds one placement step after those.
// A drain runs one rotation, and a drain of an empty list never leaves idle.
// The block is busy while it works and ignores start. Results come out one per cycle with
// strobe high, in the cycle after the step that decides them; the receiver cannot stall, so
// a drain delivers its items on consecutive cycles. Item results may appear before busy
// drops while the ring finishes its rotation.
`default_nettype none

module dirty_rect_accumulator_unit #(
  parameter int MAX_RECTS  = dra_pkg::MAX_RECTS_DEF,
  parameter int COORD_BITS = dra_pkg::COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  dra_pkg::req_t req,
  output logic          busy,
  output dra_pkg::res_t res,
  output logic          strobe
);
  import dra_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int RW    = 4 * CB;
  localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W = $clog2(MAX_RECTS + 1);
  localparam int PEN   = (MAX_RECTS > 1) ? MAX_RECTS - 2 : 0;

  typedef enum logic [2:0] {S_IDLE, S_CONT, S_MERGE, S_PLACE, S_DRAIN} state_t;

  state_t     state;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] count;
  logic       found;
  logic       merged;

  logic [RW-1:0] q [MAX_RECTS];
  logic [RW-1:0] head, tail, new_rect, oper, nr, uni, uni_q, wr_data;
  logic          contain, merge_hit, hit_now, cont_hit, shift, wr_en;
  logic [IDX_W-1:0] wr_pos;
  logic [MAX_RECTS-1:0] loads;
  eval_ctl_t     ectl;

  assign head = q[0];
  assign tail = q[MAX_RECTS-1];
  assign busy = (state != S_IDLE);

  assign new_rect = {CB'(req.rect_left), CB'(req.rect_top),
                     CB'(req.rect_right), CB'(req.rect_bottom)};
  assign oper     = (state == S_PLACE) ? tail : head;

  assign shift    = (state == S_CONT) || (state == S_DRAIN) ||
                    ((state == S_MERGE) && (cnt < CNT_W'(MAX_RECTS)));
  assign hit_now  = (state == S_MERGE) && !merged && merge_hit;
  assign cont_hit = (state == S_CONT) && (cnt < count) && !found && contain;

  assign ectl.load_new = (state == S_IDLE) && start && (req.req_type == REQ_ADD);
  assign ectl.eval_en  = (state == S_MERGE) && (cnt < count) && !merged && !hit_now;

  // A merge decision comes in the cycle after its entry is evaluated: by then the entry has rotated
  // to the tail, so it lands one place below the tail while rotating, or at the tail at the end.
  always_comb begin
    wr_en   = 1'b0;
    wr_pos  = '0;
    wr_data = uni_q;
    if (hit_now) begin
      wr_en  = 1'b1;
      wr_pos = (cnt == CNT_W'(MAX_RECTS)) ? IDX_W'(MAX_RECTS - 1) : IDX_W'(PEN);
    end else if (state == S_PLACE) begin
      wr_en = 1'b1;
      if (count < CNT_W'(MAX_RECTS)) begin
        wr_pos  = count[IDX_W-1:0];
        wr_data = nr;
      end else begin
        wr_pos  = IDX_W'(MAX_RECTS - 1);
        wr_data = uni;
      end
    end
  end

  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    cell_ctl_t cctl;
    assign loads[i]   = wr_en && (wr_pos == IDX_W'(i));
    assign cctl.shift = shift;
    assign cctl.load  = loads[i];
    dra_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk     (clk),
      .ctl     (cctl),
      .d_shift (q[(i + 1) % MAX_RECTS]),
      .d_load  (wr_data),
      .q       (q[i])
    );
  end

  dra_eval #(.COORD_BITS(COORD_BITS)) u_eval (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ectl),
    .new_rect  (new_rect),
    .oper      (oper),
    .nr        (nr),
    .contain   (contain),
    .uni       (uni),
    .merge_hit (merge_hit),
    .uni_q     (uni_q)
  );

  function automatic res_t mk_res(input logic [1:0] status, input logic [CNT_W-1:0] idx,
                                  input logic [RW-1:0] x, input logic empty,
                                  input logic last);
    res_t r;
    r.add_status  = status;
    r.entry_index = 4'(idx);
    r.out_left    = FIELD_W'(x[4*CB-1 -: CB]);
    r.out_top     = FIELD_W'(x[3*CB-1 -: CB]);
    r.out_right   = FIELD_W'(x[2*CB-1 -: CB]);
    r.out_bottom  = FIELD_W'(x[CB-1 -: CB]);
    r.list_empty  = empty;
    r.last_item   = last;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      count  <= '0;
      found  <= 1'b0;
      merged <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          cnt    <= '0;
          found  <= 1'b0;
          merged <= 1'b0;
          if (start) begin
            if (req.req_type == REQ_DRAIN) begin
              if (count == '0) begin
                strobe <= 1'b1;
                res    <= mk_res(ST_CONTAINED, '0, '0, 1'b1, 1'b1);
              end else begin
                state <= S_DRAIN;
              end
            end else begin
              state <= S_CONT;
            end
          end
        end
        S_CONT: begin
          if (cont_hit) begin
            found  <= 1'b1;
            strobe <= 1'b1;
            res    <= mk_res(ST_CONTAINED, cnt, head, 1'b0, 1'b1);
          end
          if (cnt == CNT_W'(MAX_RECTS - 1)) begin
            cnt   <= '0;
            state <= (found || cont_hit) ? S_IDLE : S_MERGE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_MERGE: begin
          if (hit_now) begin
            merged <= 1'b1;
            strobe <= 1'b1;
            res    <= mk_res(ST_MERGED, CNT_W'(cnt - CNT_W'(1)), uni_q, 1'b0, 1'b1);
          end
          if (cnt == CNT_W'(MAX_RECTS)) begin
            cnt   <= '0;
            state <= (merged || hit_now) ? S_IDLE : S_PLACE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_PLACE: begin
          strobe <= 1'b1;
          state  <= S_IDLE;
          if (count < CNT_W'(MAX_RECTS)) begin
            count <= count + CNT_W'(1);
            res   <= mk_res(ST_APPENDED, count, nr, 1'b0, 1'b1);
          end else begin
            res <= mk_res(ST_FORCED, CNT_W'(MAX_RECTS - 1), uni, 1'b0, 1'b1);
          end
        end
        S_DRAIN: begin
          if (cnt < count) begin
            strobe <= 1'b1;
            res    <= mk_res(ST_CONTAINED, cnt, head, 1'b0,
                             (CNT_W'(cnt + CNT_W'(1)) == count));
          end
          if (cnt == CNT_W'(MAX_RECTS - 1)) begin
            cnt   <= '0;
            count <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // At most one cell takes a direct write in any cycle.
  a_one_load: assert property (@(posedge clk) disable iff (rst) $onehot0(loads))
    else $error("more than one ring cell loaded in a cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RECTS))
    else $error("stored rectangle count exceeds the ring size");

  // An empty drain reports a single zero item.
  a_empty_item: assert property (@(posedge clk) disable iff (rst)
    strobe && res.list_empty |-> res.last_item && (res.entry_index == 4'd0))
    else $error("empty drain item malformed");

  // A merge only ever finishes while the merge rotation is running.
  a_merge_state: assert property (@(posedge clk) disable iff (rst)
    hit_now |-> (cnt != '0))
    else $error("merge decision without a preceding evaluation");

endmodule

`default_nettype wire

/* hw/rtl/dra_cell.sv */
// One storage cell of the rectangle ring: holds one rectangle and passes it on.
// Depends on dra_pkg for the control struct.
`default_nettype none

module dra_cell #(
  parameter int COORD_BITS = dra_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  dra_pkg::cell_ctl_t      ctl,
  input  logic [4*COORD_BITS-1:0] d_shift,
  input  logic [4*COORD_BITS-1:0] d_load,
  output logic [4*COORD_BITS-1:0] q
);
  import dra_pkg::*;

  // A direct load wins over the ring shift so a merged entry can land in place.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= d_load;
    end else if (ctl.shift) begin
      q <= d_shift;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dra_eval.sv */
// Rectangle evaluation unit: containment test, union, and a two-stage area compare.
// Depends on dra_pkg for the control struct.
`default_nettype none

module dra_eval #(
  parameter int COORD_BITS = dra_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dra_pkg::eval_ctl_t      ctl,
  input  logic [4*COORD_BITS-1:0] new_rect,
  input  logic [4*COORD_BITS-1:0] oper,
  output logic [4*COORD_BITS-1:0] nr,
  output logic                    contain,
  output logic [4*COORD_BITS-1:0] uni,
  output logic                    merge_hit,
  output logic [4*COORD_BITS-1:0] uni_q
);
  import dra_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int RW = 4 * CB;
  localparam int AW = 2 * CB;

  logic [RW-1:0] nr_q;
  logic [AW-1:0] na_q;
  logic          v_q;
  logic [AW-1:0] ua_q;
  logic [AW-1:0] sa_q;
  logic [RW-1:0] un_q;

  function automatic logic [AW-1:0] area(input logic [RW-1:0] x);
    logic [CB-1:0] l, t, r, b, w, h;
    l = x[4*CB-1 -: CB];
    t = x[3*CB-1 -: CB];
    r = x[2*CB-1 -: CB];
    b = x[CB-1 -: CB];
    w = (r > l) ? CB'(r - l) : '0;
    h = (b > t) ? CB'(b - t) : '0;
    return AW'(w) * AW'(h);
  endfunction

  function automatic logic [RW-1:0] box_union(input logic [RW-1:0] a, input logic [RW-1:0] x);
    logic [CB-1:0] l, t, r, b;
    l = (a[4*CB-1 -: CB] < x[4*CB-1 -: CB]) ? a[4*CB-1 -: CB] : x[4*CB-1 -: CB];
    t = (a[3*CB-1 -: CB] < x[3*CB-1 -: CB]) ? a[3*CB-1 -: CB] : x[3*CB-1 -: CB];
    r = (a[2*CB-1 -: CB] > x[2*CB-1 -: CB]) ? a[2*CB-1 -: CB] : x[2*CB-1 -: CB];
    b = (a[CB-1 -: CB]   > x[CB-1 -: CB])   ? a[CB-1 -: CB]   : x[CB-1 -: CB];
    return {l, t, r, b};
  endfunction

  assign nr  = nr_q;
  assign uni = box_union(oper, nr_q);

  assign contain = (oper[4*CB-1 -: CB] <= nr_q[4*CB-1 -: CB]) &&
                   (oper[3*CB-1 -: CB] <= nr_q[3*CB-1 -: CB]) &&
                   (oper[2*CB-1 -: CB] >= nr_q[2*CB-1 -: CB]) &&
                   (oper[CB-1 -: CB]   >= nr_q[CB-1 -: CB]);

  // Second stage: merge only when the union is smaller than the two areas summed.
  assign merge_hit = v_q && ((AW+1)'(ua_q) < ((AW+1)'(sa_q) + (AW+1)'(na_q)));
  assign uni_q     = un_q;

  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      nr_q <= new_rect;
      na_q <= area(new_rect);
    end
    if (ctl.eval_en) begin
      ua_q <= area(uni);
      sa_q <= area(oper);
      un_q <= uni;
    end
    if (rst) begin
      v_q <= 1'b0;
    end else begin
      v_q <= ctl.eval_en;
    end
  end

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for dirty_rect_accumulator_unit: directed and random add/drain items.
// Depends on dra_pkg and the RTL of dirty_rect_accumulator_unit; a scoreboard class predicts
// every result from its own copy of the rectangle list.
`default_nettype none

module testbench;
  import dra_pkg::*;

  localparam int DEPTH     = MAX_RECTS_DEF;
  localparam int CMAX      = (1 << FIELD_W) - 1;
  localparam int SETTLE    = 2 * DEPTH + 8;
  localparam int MAX_PRINT = 60;

  typedef struct packed {
    logic [FIELD_W-1:0] l;
    logic [FIELD_W-1:0] t;
    logic [FIELD_W-1:0] r;
    logic [FIELD_W-1:0] b;
  } box_t;

  class rect_scoreboard;
    box_t rects[DEPTH];
    int   count;
    res_t expected[$];
    int   fails;

    function new();
      count = 0;
      fails = 0;
    endfunction

    task report_mismatch(input string msg);
      if (fails < MAX_PRINT) $display("[%0t] mismatch: %s", $realtime, msg);
      fails++;
    endtask

    function longint unsigned area(box_t x);
      longint unsigned w;
      longint unsigned h;
      w = (x.r > x.l) ? longint'(x.r) - longint'(x.l) : 0;
      h = (x.b > x.t) ? longint'(x.b) - longint'(x.t) : 0;
      return w * h;
    endfunction

    function box_t union_of(box_t a, box_t x);
      box_t u;
      u.l = (a.l < x.l) ? a.l : x.l;
      u.t = (a.t < x.t) ? a.t : x.t;
      u.r = (a.r > x.r) ? a.r : x.r;
      u.b = (a.b > x.b) ? a.b : x.b;
      return u;
    endfunction

    function void push_result(logic [1:0] status, int idx, box_t x, logic empty, logic last);
      res_t e;
      e.add_status  = status;
      e.entry_index = idx[3:0];
      e.out_left    = x.l;
      e.out_top     = x.t;
      e.out_right   = x.r;
      e.out_bottom  = x.b;
      e.list_empty  = empty;
      e.last_item   = last;
      expected = {expected, e};
    endfunction

    // Works out the results of one accepted item and updates the list.
    function void note_request(req_t q);
      box_t nr;
      box_t u;
      box_t zero;
      zero = '0;
      if (q.req_type == REQ_DRAIN) begin
        if (count == 0) begin
          push_result(ST_CONTAINED, 0, zero, 1'b1, 1'b1);
        end else begin
          for (int i = 0; i < count; i++)
            push_result(ST_CONTAINED, i, rects[i], 1'b0, i + 1 == count);
        end
        count = 0;
        return;
      end
      nr.l = q.rect_left;
      nr.t = q.rect_top;
      nr.r = q.rect_right;
      nr.b = q.rect_bottom;
      for (int i = 0; i < count; i++) begin
        if (rects[i].l <= nr.l && rects[i].t <= nr.t &&
            rects[i].r >= nr.r && rects[i].b >= nr.b) begin
          push_result(ST_CONTAINED, i, rects[i], 1'b0, 1'b1);
          return;
        end
      end
      for (int i = 0; i < count; i++) begin
        u = union_of(rects[i], nr);
        if (area(u) < area(rects[i]) + area(nr)) begin
          rects[i] = u;
          push_result(ST_MERGED, i, u, 1'b0, 1'b1);
          return;
        end
      end
      if (count < DEPTH) begin
        rects[count] = nr;
        push_result(ST_APPENDED, count, nr, 1'b0, 1'b1);
        count++;
        return;
      end
      rects[DEPTH-1] = union_of(rects[DEPTH-1], nr);
      push_result(ST_FORCED, DEPTH - 1, rects[DEPTH-1], 1'b0, 1'b1);
    endfunction

    task check_field(input string name, input logic [FIELD_W-1:0] got,
                     input logic [FIELD_W-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(input res_t got);
      res_t want;
      if (expected.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
        return;
      end
      want = expected.pop_front();
      check_field("add_status", FIELD_W'(got.add_status), FIELD_W'(want.add_status));
      check_field("entry_index", FIELD_W'(got.entry_index), FIELD_W'(want.entry_index));
      check_field("out_left", got.out_left, want.out_left);
      check_field("out_top", got.out_top, want.out_top);
      check_field("out_right", got.out_right, want.out_right);
      check_field("out_bottom", got.out_bottom, want.out_bottom);
      check_field("list_empty", FIELD_W'(got.list_empty), FIELD_W'(want.list_empty));
      check_field("last_item", FIELD_W'(got.last_item), FIELD_W'(want.last_item));
    endtask

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  req_t req;
  logic busy;
  res_t res;
  logic strobe;

  rect_scoreboard sb = new();

  dirty_rect_accumulator_unit uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .res    (res),
    .strobe (strobe)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(res);
  end

  function automatic req_t add_req(int l, int t, int r, int b);
    req_t q;
    q.req_type    = REQ_ADD;
    q.rect_left   = l[FIELD_W-1:0];
    q.rect_top    = t[FIELD_W-1:0];
    q.rect_right  = r[FIELD_W-1:0];
    q.rect_bottom = b[FIELD_W-1:0];
    return q;
  endfunction

  function automatic req_t drain_req();
    req_t q;
    q = '0;
    q.req_type = REQ_DRAIN;
    return q;
  endfunction

  function automatic int edge_coord();
    int c;
    c = $urandom_range(0, CMAX);
    if ($urandom_range(0, 3) == 0) c = $urandom_range(0, 1) ? CMAX : 0;
    return c;
  endfunction

  // Holds start low for the drawn gap, then offers the item until the block takes it.
  task automatic send_request(input req_t q, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= q;
    do @(posedge clk); while (busy);
    sb.note_request(q);
  endtask

  initial begin
    req_t directed[$];
    req_t q;
    box_t e;
    int   quiet;
    int   to_drain;
    int   cx;
    int   cy;
    int   kind;
    int   l;
    int   t;
    int   span_x;
    int   span_y;
    int   waited;

    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    directed = {directed, drain_req()};                    // drain of an empty list
    directed = {directed, add_req(10, 10, 20, 20)};
    directed = {directed, add_req(12, 12, 18, 18)};        // already covered
    directed = {directed, add_req(12, 10, 22, 20)};        // overlapping, merges
    directed = {directed, add_req(100, 100, 50, 200)};     // zero width
    directed = {directed, add_req(300, 300, 400, 250)};    // zero height
    directed = {directed, add_req(0, 0, 0, 0)};
    directed = {directed, add_req(0, 0, CMAX, CMAX)};      // whole screen
    directed = {directed, add_req(CMAX, CMAX, 0, 0)};
    directed = {directed, drain_req()};
    // Far-apart single pixels fill the list; the last one is forced into the final entry.
    for (int i = 0; i <= DEPTH; i++)
      directed = {directed,
                  add_req(i * 240 + 1, i * 240 + 2, i * 240 + 2, i * 240 + 3)};
    directed = {directed, add_req(CMAX - 1, CMAX - 1, CMAX, CMAX)};
    directed = {directed, drain_req()};
    foreach (directed[i]) send_request(directed[i], $urandom_range(0, 13));

    quiet    = 0;
    to_drain = $urandom_range(3, 40);
    cx       = $urandom_range(0, 3800);
    cy       = $urandom_range(0, 3800);
    for (int k = 0; k < 100; k++) begin
      if (k % 20 == 0) quiet = $urandom_range(0, 1);
      kind = $urandom_range(0, 99);
      if (to_drain == 0) begin
        q        = drain_req();
        to_drain = $urandom_range(3, 40);
        cx       = $urandom_range(0, 3800);
        cy       = $urandom_range(0, 3800);
      end else begin
        to_drain--;
        if (kind < 35) begin
          // Rectangles around one spot tend to overlap and merge.
          l = cx + $urandom_range(0, 120);
          t = cy + $urandom_range(0, 120);
          q = add_req(l, t, l + $urandom_range(1, 80), t + $urandom_range(1, 80));
        end else if (kind < 65) begin
          l = $urandom_range(0, CMAX - 4);
          t = $urandom_range(0, CMAX - 4);
          q = add_req(l, t, l + $urandom_range(1, 3), t + $urandom_range(1, 3));
        end else if (kind < 85 || sb.count == 0) begin
          q = add_req(edge_coord(), edge_coord(), edge_coord(), edge_coord());
        end else begin
          // A piece of a stored rectangle.
          e      = sb.rects[$urandom_range(0, sb.count - 1)];
          span_x = (e.r > e.l) ? (e.r - e.l) / 2 : 0;
          span_y = (e.b > e.t) ? (e.b - e.t) / 2 : 0;
          q = add_req(e.l + $urandom_range(0, span_x), e.t + $urandom_range(0, span_y),
                      e.r - $urandom_range(0, span_x), e.b - $urandom_range(0, span_y));
        end
      end
      send_request(q, quiet ? 0 : $urandom_range(0, 13));
    end
    start <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

    if (sb.fails == 0) begin
      $display("dirty_rect_accumulator_unit test passed");
    end else begin
      $display("dirty_rect_accumulator_unit test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("dirty_rect_accumulator_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/dra_pkg.sv
hw/rtl/dra_cell.sv
hw/rtl/dra_eval.sv
hw/rtl/dirty_rect_accumulator_unit.sv
bench/testbench.sv
